### sv/svpg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpg_pkg
// Types, register indexes and reset values for the supply voltage
// plausibility guard.
// ----------------------------------------------------------------------------
package svpg_pkg;

  localparam logic [5:0]  DEFAULT_CELLS         = 6'd16;
  localparam logic [5:0]  RST_CELL_COUNT        = 6'd0;
  localparam logic [13:0] RST_MAX_CELL_MV       = 14'd4300;
  localparam logic [13:0] RST_MIN_CELL_MV       = 14'd2500;
  localparam logic [15:0] RST_STEP_FRAC_Q16     = 16'd6554;
  localparam logic [15:0] RST_DISTRUST_LIMIT_MS = 16'd2000;

  localparam logic [18:0] MV_MAX       = 19'h7FFFF;
  localparam logic [16:0] DISTRUST_MAX = 17'h1FFFF;

  typedef enum logic [2:0] {
    REG_CELL_COUNT        = 3'd0,
    REG_MAX_CELL_MV       = 3'd1,
    REG_MIN_CELL_MV       = 3'd2,
    REG_STEP_FRAC_Q16     = 3'd3,
    REG_DISTRUST_LIMIT_MS = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic signed [19:0] supply_mv;
    logic               supply_ok;
    logic signed [19:0] pack_mv;
    logic               pack_ok;
    logic        [15:0] elapsed_ms;
  } in_item_t;

  typedef struct packed {
    logic [18:0] clamp_mv;
    logic        clamp_ok;
    logic        implausible;
  } out_item_t;

endpackage

### sv/supply_voltage_plausibility_guard_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// supply_voltage_plausibility_guard_core
// Picks the higher valid supply reading, checks it against the cell band and
// tracks a trusted level that holds off large downward steps.
// ----------------------------------------------------------------------------
// pipeline: an input transaction passes the input register, then the result
//   register, before the result is valid
// throughput: one item per cycle while out_ready holds no result back; the tracked
//   level is updated between the two registers, with one 19x17 multiply for the step test
// reset: synchronous, clears pipeline valids and the tracked level, and loads
//   the configuration reset values
module supply_voltage_plausibility_guard_core
  import svpg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // configuration
  logic [5:0]  cell_count;
  logic [13:0] max_cell_mv;
  logic [13:0] min_cell_mv;
  logic [15:0] step_frac_q16;
  logic [15:0] distrust_limit_ms;

  // pipeline
  logic      s1_valid;
  in_item_t  s1_item;
  logic      advance;

  // tracker state
  logic [18:0] tracked_mv;
  logic        tracked_ok;
  logic [16:0] distrust_time;
  logic [18:0] tracked_mv_next;
  logic        tracked_ok_next;
  logic [16:0] distrust_time_next;
  out_item_t   result;

  // datapath
  logic               any_ok;
  logic signed [19:0] v;
  logic [5:0]         cells;
  logic [19:0]        v_hi;
  logic [19:0]        v_lo;
  logic               below;
  logic [18:0]        v_u;
  logic [18:0]        hi_sat;
  logic [18:0]        clip;
  logic [16:0]        factor;
  logic [35:0]        track_prod;
  logic [35:0]        v_scaled;
  logic               follow;
  logic [17:0]        dsum;
  logic [16:0]        dsat;
  logic               reanchor;
  logic [18:0]        track_upd;
  logic [16:0]        dist_upd;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || out_ready;
  assign in_ready  = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_count        <= RST_CELL_COUNT;
      max_cell_mv       <= RST_MAX_CELL_MV;
      min_cell_mv       <= RST_MIN_CELL_MV;
      step_frac_q16     <= RST_STEP_FRAC_Q16;
      distrust_limit_ms <= RST_DISTRUST_LIMIT_MS;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CELL_COUNT:        cell_count        <= cfg_data[5:0];
        REG_MAX_CELL_MV:       max_cell_mv       <= cfg_data[13:0];
        REG_MIN_CELL_MV:       min_cell_mv       <= cfg_data[13:0];
        REG_STEP_FRAC_Q16:     step_frac_q16     <= cfg_data;
        REG_DISTRUST_LIMIT_MS: distrust_limit_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    any_ok = s1_item.supply_ok || s1_item.pack_ok;
    if (s1_item.pack_ok && (!s1_item.supply_ok || s1_item.pack_mv > s1_item.supply_mv)) begin
      v = s1_item.pack_mv;
    end else begin
      v = s1_item.supply_mv;
    end

    cells = (cell_count == 6'd0) ? DEFAULT_CELLS : cell_count;
    v_hi  = 20'(max_cell_mv) * 20'(cells);
    v_lo  = 20'(min_cell_mv) * 20'(cells);
    below = $signed({v[19], v}) < $signed({1'b0, v_lo});

    // in band the reading is known non-negative and fits 19 bits
    v_u    = v[18:0];
    hi_sat = (v_hi > 20'(MV_MAX)) ? MV_MAX : v_hi[18:0];
    clip   = ({1'b0, v_u} < v_hi) ? v_u : v_hi[18:0];

    // with no track held the seeded level always passes the step test
    factor     = 17'h10000 - {1'b0, step_frac_q16};
    track_prod = 36'(tracked_mv) * 36'(factor);
    v_scaled   = {1'b0, v_u, 16'h0000};
    follow     = !tracked_ok || (v_scaled >= track_prod);

    dsum     = 18'(distrust_time) + 18'(s1_item.elapsed_ms);
    dsat     = dsum[17] ? DISTRUST_MAX : dsum[16:0];
    reanchor = dsat >= {1'b0, distrust_limit_ms};

    if (follow) begin
      track_upd = clip;
      dist_upd  = '0;
    end else if (reanchor) begin
      track_upd = v_u;
      dist_upd  = '0;
    end else begin
      track_upd = tracked_mv;
      dist_upd  = dsat;
    end

    tracked_mv_next    = tracked_mv;
    tracked_ok_next    = tracked_ok;
    distrust_time_next = distrust_time;
    result             = '0;

    priority if (!any_ok) begin
      result = '0;
    end else if (below) begin
      result.clamp_ok    = 1'b1;
      result.implausible = 1'b1;
      result.clamp_mv    = (tracked_ok && {1'b0, tracked_mv} >= v_lo) ? tracked_mv : hi_sat;
    end else begin
      tracked_mv_next    = track_upd;
      tracked_ok_next    = 1'b1;
      distrust_time_next = dist_upd;
      result.clamp_ok    = 1'b1;
      result.implausible = !follow;
      result.clamp_mv    = (v_u > track_upd) ? v_u : track_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      out_valid     <= 1'b0;
      tracked_mv    <= '0;
      tracked_ok    <= 1'b0;
      distrust_time <= '0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= s1_valid;
      end
      // state moves only when the item leaves the input register
      if (s1_valid && advance) begin
        tracked_mv    <= tracked_mv_next;
        tracked_ok    <= tracked_ok_next;
        distrust_time <= distrust_time_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_item;
    end
    if (s1_valid && advance) begin
      out_item <= result;
    end
  end

endmodule

### sv/svpg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpg_checker
// Port-level checks for the supply voltage plausibility guard.
// ----------------------------------------------------------------------------
module svpg_checker
  import svpg_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input out_item_t   out_item
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // no reading means an all-zero result
  a_no_reading: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.clamp_ok |-> out_item.clamp_mv == '0 && !out_item.implausible)
    else $error("no-reading result not zero");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // an empty output register never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

bind supply_voltage_plausibility_guard_core svpg_checker u_svpg_checker (.*);
